### hw/rtl/ssf_pkg.sv
// Shared types, constants and helper functions for the scanline span fill block.
package ssf_pkg;

  // Line geometry
  localparam int LINE_BYTES = 1024;
  localparam int ADDR_W     = 10;          // byte index into the line
  localparam int CNT_W      = ADDR_W + 1;  // byte count, holds LINE_BYTES itself
  localparam int COL_W      = 13;          // pixel column
  localparam int ACT_W      = 2;
  localparam int ROP_W      = 2;
  localparam int BCNT_W     = 4;

  localparam logic [CNT_W-1:0] LINE_BYTES_C = CNT_W'(LINE_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX_C   = CNT_W'(LINE_BYTES - 1);

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  typedef enum logic [ACT_W-1:0] {
    ACT_SPAN  = 2'd0,
    ACT_BLANK = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [ROP_W-1:0] {
    ROP_SET  = 2'd0,
    ROP_CLR  = 2'd1,
    ROP_INV  = 2'd2,
    ROP_NOP  = 2'd3
  } rop_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_BLANK,
    ST_RD,
    ST_RD_DATA,
    ST_FINISH
  } state_t;

  function automatic logic [BCNT_W-1:0] popcount8(input logic [7:0] v);
    logic [BCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + BCNT_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [7:0] apply_rop(input logic [7:0] d, input logic [7:0] m,
                                           input logic [ROP_W-1:0] op);
    logic [7:0] r;
    case (op)
      ROP_SET: r = d | m;
      ROP_CLR: r = d & ~m;
      ROP_INV: r = d ^ m;
      default: r = d;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/ssf_if.sv
// Request and result channel interfaces for the scanline span fill block.
interface ssf_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssf_pkg::ACT_W-1:0]  action;
  logic [ssf_pkg::COL_W-1:0]  x_first;
  logic [ssf_pkg::COL_W-1:0]  x_last;
  logic [ssf_pkg::ROP_W-1:0]  raster_op;
  logic [ssf_pkg::ADDR_W-1:0] byte_addr;
  logic                       blank_dark;

  modport source (output valid, action, x_first, x_last, raster_op, byte_addr, blank_dark,
                  input ready);
  modport sink   (input valid, action, x_first, x_last, raster_op, byte_addr, blank_dark,
                  output ready);
endinterface

interface ssf_out_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 read_byte;
  logic [ssf_pkg::BCNT_W-1:0] set_bit_count;
  logic                       out_of_range;

  modport source (output valid, read_byte, set_bit_count, out_of_range, input ready);
  modport sink   (input valid, read_byte, set_bit_count, out_of_range, output ready);
endinterface

### hw/rtl/scanline_span_fill_core.sv
// Top level: monochrome scanline store with span raster ops, blank and byte read-back.
//
// Request handling: a rejected span, raster op 3 or action 3 goes straight to the result;
//   a read fetches the byte and counts its set bits; span and blank sweep their bytes.
// Throughput: one request at a time; the single read-modify-write path over the byte-wide
//   line memory handles one byte per cycle, which sets span and blank length.
// Reset: synchronous, active low. Afterwards a clearing pass writes zero to all 1024 bytes
//   with in_ch.ready low; config writes are taken meanwhile.
module scanline_span_fill_core (
  input  logic                        clk,
  input  logic                        rst_n,
  ssf_in_if.sink                      in_ch,
  ssf_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [ssf_pkg::CNT_W-1:0]   cfg_wdata
);

  // ---------------------------------------------------------------------------
  // State and registers
  // ---------------------------------------------------------------------------
  ssf_pkg::state_t state_r, state_nxt;

  logic [ssf_pkg::CNT_W-1:0]  width_cfg_r;        // active_bytes register

  logic [ssf_pkg::CNT_W-1:0]  ptr_r, ptr_nxt;     // sweep / span byte pointer
  logic [ssf_pkg::CNT_W-1:0]  lim_r, lim_nxt;     // blank sweep length
  logic [ssf_pkg::ADDR_W-1:0] p1_r, p1_nxt;       // first span byte
  logic [ssf_pkg::ADDR_W-1:0] p2_r, p2_nxt;       // last span byte
  logic [7:0]                 mfirst_r, mfirst_nxt;
  logic [7:0]                 mlast_r, mlast_nxt;
  logic [ssf_pkg::ROP_W-1:0]  op_r, op_nxt;
  logic [7:0]                 fill_r, fill_nxt;
  logic [ssf_pkg::ADDR_W-1:0] addr_r, addr_nxt;

  // span write-back stage (one read in flight)
  logic                       wb_v_r, wb_v_nxt;
  logic [ssf_pkg::ADDR_W-1:0] wb_addr_r, wb_addr_nxt;

  // pending result
  logic [7:0]                 res_byte_r, res_byte_nxt;
  logic [ssf_pkg::BCNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                       res_oor_r, res_oor_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, out_byte_nxt;
  logic [ssf_pkg::BCNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                       out_oor_r, out_oor_nxt;

  // line memory
  logic [7:0]                 line_mem [ssf_pkg::LINE_BYTES];
  logic [7:0]                 rd_data_r;
  logic                       mem_we, rd_en;
  logic [ssf_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]                 wr_data;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                       in_acc;
  logic                       out_free;
  logic [ssf_pkg::CNT_W-1:0]  eff_w;
  logic [ssf_pkg::COL_W-1:0]  col_lo, col_hi;
  logic [ssf_pkg::ADDR_W-1:0] in_p1, in_p2;
  logic                       span_oor, read_oor;
  logic [7:0]                 span_mask;

  assign in_ch.ready = (state_r == ssf_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // active width saturated to the line size
  assign eff_w = (width_cfg_r > ssf_pkg::LINE_BYTES_C) ? ssf_pkg::LINE_BYTES_C : width_cfg_r;

  assign col_lo   = (in_ch.x_first < in_ch.x_last) ? in_ch.x_first : in_ch.x_last;
  assign col_hi   = (in_ch.x_first < in_ch.x_last) ? in_ch.x_last  : in_ch.x_first;
  assign in_p1    = col_lo[ssf_pkg::COL_W-1:3];
  assign in_p2    = col_hi[ssf_pkg::COL_W-1:3];
  assign span_oor = ({1'b0, in_p2} >= eff_w);
  assign read_oor = ({1'b0, in_ch.byte_addr} >= eff_w);

  // per-byte mask: partial at the end bytes, full in between
  assign span_mask = ((wb_addr_r == p1_r) ? mfirst_r : ssf_pkg::BYTE_ONES) &
                     ((wb_addr_r == p2_r) ? mlast_r  : ssf_pkg::BYTE_ONES);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssf_pkg::ST_CLEAR: begin
        if (ptr_r == ssf_pkg::LAST_IDX_C) state_nxt = ssf_pkg::ST_IDLE;
      end
      ssf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (ssf_pkg::action_t'(in_ch.action))
            ssf_pkg::ACT_SPAN: begin
              if (span_oor || in_ch.raster_op == ssf_pkg::ROP_NOP)
                state_nxt = ssf_pkg::ST_FINISH;
              else state_nxt = ssf_pkg::ST_SPAN;
            end
            ssf_pkg::ACT_BLANK: begin
              if (eff_w == '0) state_nxt = ssf_pkg::ST_FINISH;
              else state_nxt = ssf_pkg::ST_BLANK;
            end
            ssf_pkg::ACT_READ: begin
              if (read_oor) state_nxt = ssf_pkg::ST_FINISH;
              else state_nxt = ssf_pkg::ST_RD;
            end
            default: state_nxt = ssf_pkg::ST_FINISH;
          endcase
        end
      end
      ssf_pkg::ST_SPAN: begin
        if (ptr_r > {1'b0, p2_r} && !wb_v_r) state_nxt = ssf_pkg::ST_FINISH;
      end
      ssf_pkg::ST_BLANK: begin
        if (ptr_r == lim_r - ssf_pkg::CNT_W'(1)) state_nxt = ssf_pkg::ST_FINISH;
      end
      ssf_pkg::ST_RD:      state_nxt = ssf_pkg::ST_RD_DATA;
      ssf_pkg::ST_RD_DATA: state_nxt = ssf_pkg::ST_FINISH;
      ssf_pkg::ST_FINISH: begin
        if (out_free) state_nxt = ssf_pkg::ST_IDLE;
      end
      default: state_nxt = ssf_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    ptr_nxt      = ptr_r;
    lim_nxt      = lim_r;
    p1_nxt       = p1_r;
    p2_nxt       = p2_r;
    mfirst_nxt   = mfirst_r;
    mlast_nxt    = mlast_r;
    op_nxt       = op_r;
    fill_nxt     = fill_r;
    addr_nxt     = addr_r;
    wb_v_nxt     = 1'b0;
    wb_addr_nxt  = wb_addr_r;
    res_byte_nxt = res_byte_r;
    res_cnt_nxt  = res_cnt_r;
    res_oor_nxt  = res_oor_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt = out_byte_r;
    out_cnt_nxt  = out_cnt_r;
    out_oor_nxt  = out_oor_r;
    mem_we       = 1'b0;
    wr_addr      = ptr_r[ssf_pkg::ADDR_W-1:0];
    wr_data      = ssf_pkg::BYTE_ZEROS;
    rd_en        = 1'b0;
    rd_addr      = ptr_r[ssf_pkg::ADDR_W-1:0];

    case (state_r)
      ssf_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + ssf_pkg::CNT_W'(1);
      end
      ssf_pkg::ST_IDLE: begin
        if (in_acc) begin
          p1_nxt       = in_p1;
          p2_nxt       = in_p2;
          mfirst_nxt   = ssf_pkg::BYTE_ONES >> col_lo[2:0];
          mlast_nxt    = ssf_pkg::BYTE_ONES << (3'd7 - col_hi[2:0]);
          op_nxt       = in_ch.raster_op;
          fill_nxt     = in_ch.blank_dark ? ssf_pkg::BYTE_ONES : ssf_pkg::BYTE_ZEROS;
          addr_nxt     = in_ch.byte_addr;
          lim_nxt      = eff_w;
          ptr_nxt      = (in_ch.action == ssf_pkg::ACT_SPAN) ? {1'b0, in_p1} : '0;
          res_byte_nxt = '0;
          res_cnt_nxt  = '0;
          case (ssf_pkg::action_t'(in_ch.action))
            ssf_pkg::ACT_SPAN: res_oor_nxt = span_oor;
            ssf_pkg::ACT_READ: res_oor_nxt = read_oor;
            default:           res_oor_nxt = 1'b0;
          endcase
        end
      end
      ssf_pkg::ST_SPAN: begin
        // read byte k while writing back byte k-1
        rd_en       = (ptr_r <= {1'b0, p2_r});
        wb_v_nxt    = rd_en;
        wb_addr_nxt = ptr_r[ssf_pkg::ADDR_W-1:0];
        if (rd_en) ptr_nxt = ptr_r + ssf_pkg::CNT_W'(1);
        mem_we  = wb_v_r;
        wr_addr = wb_addr_r;
        wr_data = ssf_pkg::apply_rop(rd_data_r, span_mask, op_r);
      end
      ssf_pkg::ST_BLANK: begin
        mem_we  = 1'b1;
        wr_data = fill_r;
        ptr_nxt = ptr_r + ssf_pkg::CNT_W'(1);
      end
      ssf_pkg::ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = addr_r;
      end
      ssf_pkg::ST_RD_DATA: begin
        res_byte_nxt = rd_data_r;
        res_cnt_nxt  = ssf_pkg::popcount8(rd_data_r);
      end
      ssf_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_byte_r;
          out_cnt_nxt   = res_cnt_r;
          out_oor_nxt   = res_oor_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssf_pkg::ST_CLEAR;
      width_cfg_r <= ssf_pkg::LINE_BYTES_C;
      ptr_r       <= '0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) width_cfg_r <= cfg_wdata;
      ptr_r       <= ptr_nxt;
      wb_v_r      <= wb_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    lim_r      <= lim_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    mfirst_r   <= mfirst_nxt;
    mlast_r    <= mlast_nxt;
    op_r       <= op_nxt;
    fill_r     <= fill_nxt;
    addr_r     <= addr_nxt;
    wb_addr_r  <= wb_addr_nxt;
    res_byte_r <= res_byte_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_oor_r  <= res_oor_nxt;
    out_byte_r <= out_byte_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  // line memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) line_mem[wr_addr] <= wr_data;
    if (rd_en)  rd_data_r <= line_mem[rd_addr];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_byte     = out_byte_r;
  assign out_ch.set_bit_count = out_cnt_r;
  assign out_ch.out_of_range  = out_oor_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request accepted while previous one still in work");

  a_wb_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    wb_v_r |-> (state_r == ssf_pkg::ST_SPAN) && (wb_addr_r >= p1_r) && (wb_addr_r <= p2_r))
    else $error("span write-back outside span bytes");

  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.read_byte == 8'h00) == (out_ch.set_bit_count == '0)))
    else $error("set bit count disagrees with read byte");

  a_oor_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_of_range |-> (out_ch.read_byte == 8'h00))
    else $error("rejected request returned data");

endmodule

### dv/testbench.sv
// Self-checking testbench for the scanline span fill core: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no request or result moving before the run is declared hung. The slowest
  // legal request is a blank or span over 1024 bytes; add the long sink hold-off and the
  // worst random gaps, then leave a wide margin.
  localparam int unsigned QUIET_LIMIT     = 20000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam int unsigned PHASE_REQUESTS  = 80;

  typedef struct packed {
    ssf_pkg::action_t            action;
    logic [ssf_pkg::COL_W-1:0]   x_first;
    logic [ssf_pkg::COL_W-1:0]   x_last;
    ssf_pkg::rop_t               raster_op;
    logic [ssf_pkg::ADDR_W-1:0]  byte_addr;
    logic                        blank_dark;
  } line_req_t;

  typedef struct packed {
    logic [7:0]                  read_byte;
    logic [ssf_pkg::BCNT_W-1:0]  set_bit_count;
    logic                        out_of_range;
  } line_result_t;

  // Idle behavior of either side for one phase.
  typedef enum {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_t;

  typedef enum bit {ROW_REQUEST, ROW_WIDTH} row_kind_t;
  typedef enum bit {CHECK_PREDICTED, CHECK_LISTED} row_check_t;

  typedef struct {
    row_kind_t                   kind;
    logic [ssf_pkg::CNT_W-1:0]   width;
    ssf_pkg::action_t            action;
    logic [ssf_pkg::COL_W-1:0]   x_first;
    logic [ssf_pkg::COL_W-1:0]   x_last;
    ssf_pkg::rop_t               raster_op;
    logic [ssf_pkg::ADDR_W-1:0]  byte_addr;
    logic                        blank_dark;
    row_check_t                  check;
    line_result_t                want;
  } dir_row_t;

  localparam line_result_t QUIET     = '{8'h00, 4'd0, 1'b0};
  localparam line_result_t FLAGGED   = '{8'h00, 4'd0, 1'b1};
  localparam line_result_t FULL_BYTE = '{8'hFF, 4'd8, 1'b0};

  // Directed part. Listed results hold only where they follow at a glance: reads right after
  // reset or after a blank, whole-line ops, span/blank results, and rejected requests.
  // Line starts all zero with 1024 active bytes.
  dir_row_t dir_table [30] = '{
    // read right after reset
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, QUIET},
    // whole first byte set, then read back
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd0, 13'd7, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, FULL_BYTE},
    // reversed columns covering the full line, inverted
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd8191, 13'd0, ssf_pkg::ROP_INV, 10'd0, 1'b0,
      CHECK_LISTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd1023, 1'b0,
      CHECK_LISTED, FULL_BYTE},
    // reversed span with partial masks at both ends, then read
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd13, 13'd2, ssf_pkg::ROP_CLR, 10'd0, 1'b0,
      CHECK_PREDICTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd1, 1'b0,
      CHECK_PREDICTED, QUIET},
    // single pixel
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd3, 13'd3, ssf_pkg::ROP_INV, 10'd0, 1'b0,
      CHECK_PREDICTED, QUIET},
    // unused raster op leaves the line alone, no flag
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd20, 13'd21, ssf_pkg::ROP_NOP, 10'd0, 1'b0,
      CHECK_LISTED, QUIET},
    // unused action with every field at its top
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_NONE, 13'd8191, 13'd8191, ssf_pkg::ROP_NOP, 10'd1023,
      1'b1, CHECK_LISTED, QUIET},
    // blank both ways
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_BLANK, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_BLANK, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b1,
      CHECK_LISTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, FULL_BYTE},
    // last two pixels of the line
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd8190, 13'd8191, ssf_pkg::ROP_CLR, 10'd0,
      1'b0, CHECK_PREDICTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd1023, 1'b0,
      CHECK_PREDICTED, QUIET},
    // two active bytes: spans and reads past the width are flagged and dropped
    '{ROW_WIDTH, 11'd2, ssf_pkg::ACT_NONE, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_PREDICTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd15, 13'd16, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, FLAGGED},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd0, 13'd15, ssf_pkg::ROP_INV, 10'd0, 1'b0,
      CHECK_PREDICTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd2, 1'b0,
      CHECK_LISTED, FLAGGED},
    // out of width wins over the unused raster op
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd16, 13'd8191, ssf_pkg::ROP_NOP, 10'd0, 1'b0,
      CHECK_LISTED, FLAGGED},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_BLANK, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd1, 1'b0,
      CHECK_LISTED, QUIET},
    // zero width: nothing is active, blank is a no-op
    '{ROW_WIDTH, 11'd0, ssf_pkg::ACT_NONE, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_PREDICTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_SPAN, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, FLAGGED},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_LISTED, FLAGGED},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_BLANK, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b1,
      CHECK_LISTED, QUIET},
    // top register value saturates to the full line
    '{ROW_WIDTH, 11'd2047, ssf_pkg::ACT_NONE, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd0, 1'b0,
      CHECK_PREDICTED, QUIET},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd2, 1'b0,
      CHECK_LISTED, FULL_BYTE},
    '{ROW_REQUEST, 11'd0, ssf_pkg::ACT_READ, 13'd0, 13'd0, ssf_pkg::ROP_SET, 10'd1023, 1'b0,
      CHECK_PREDICTED, QUIET}
  };

  // Register settings for the random phases, extremes included.
  int unsigned phase_widths [12] = '{1, 3, 2047, 8, 0, 33, 1024, 2, 100, 7, 1024, 16};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ssf_pkg::CNT_W-1:0] cfg_wdata;

  ssf_in_if  in_ch ();
  ssf_out_if out_ch ();

  scanline_span_fill_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: our own image of the line and the active width register.
  logic [7:0]                line_img [ssf_pkg::LINE_BYTES];
  logic [ssf_pkg::CNT_W-1:0] active_bytes_cfg;

  line_result_t queued_line_results [$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  pace_t        src_pace = PACE_LIGHT;
  pace_t        sink_pace = PACE_LIGHT;
  bit           hold_off_req = 1'b0;

  // Apply one accepted request to the line image and return the result it should give.
  function automatic line_result_t raster_line_update(input line_req_t r);
    line_result_t res;
    int unsigned  w, lo, hi, k;
    logic [7:0]   mask;
    res = QUIET;
    w = (active_bytes_cfg > ssf_pkg::LINE_BYTES) ? ssf_pkg::LINE_BYTES : active_bytes_cfg;
    case (r.action)
      ssf_pkg::ACT_SPAN: begin
        lo = (r.x_first < r.x_last) ? r.x_first : r.x_last;
        hi = (r.x_first < r.x_last) ? r.x_last : r.x_first;
        if ((hi >> 3) >= w) begin
          res.out_of_range = 1'b1;
        end else begin
          // partial masks at the end bytes, whole bytes between
          for (k = lo >> 3; k <= (hi >> 3); k++) begin
            mask = ssf_pkg::BYTE_ONES;
            if (k == (lo >> 3)) mask = mask >> (lo % 8);
            if (k == (hi >> 3)) mask = mask & (ssf_pkg::BYTE_ONES << (7 - hi % 8));
            case (r.raster_op)
              ssf_pkg::ROP_SET: line_img[k] = line_img[k] | mask;
              ssf_pkg::ROP_CLR: line_img[k] = line_img[k] & ~mask;
              ssf_pkg::ROP_INV: line_img[k] = line_img[k] ^ mask;
              default: ;
            endcase
          end
        end
      end
      ssf_pkg::ACT_BLANK: begin
        for (k = 0; k < w; k++)
          line_img[k] = r.blank_dark ? ssf_pkg::BYTE_ONES : ssf_pkg::BYTE_ZEROS;
      end
      ssf_pkg::ACT_READ: begin
        if (r.byte_addr >= w) begin
          res.out_of_range = 1'b1;
        end else begin
          res.read_byte     = line_img[r.byte_addr];
          res.set_bit_count = ssf_pkg::BCNT_W'($countones(line_img[r.byte_addr]));
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap(input pace_t pace);
    int unsigned roll;
    if (pace == PACE_STEADY) return 0;
    roll = $urandom_range(0, 99);
    if (roll < ((pace == PACE_LIGHT) ? 70 : 40)) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random request for a line of w active bytes. Unused fields carry noise.
  function automatic line_req_t random_line_request(input int unsigned w);
    line_req_t   r;
    int unsigned pick, lo, hi, pixels;
    pixels       = w * 8;
    r.x_first    = ssf_pkg::COL_W'($urandom);
    r.x_last     = ssf_pkg::COL_W'($urandom);
    r.raster_op  = ($urandom_range(0, 15) == 0) ? ssf_pkg::ROP_NOP :
                   ssf_pkg::rop_t'($urandom_range(0, 2));
    r.byte_addr  = ssf_pkg::ADDR_W'($urandom);
    r.blank_dark = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.action = ssf_pkg::ACT_SPAN;
      // mostly short spans inside the width, a few long ones; the rest keep raw columns
      if (pixels != 0 && $urandom_range(0, 9) < 8) begin
        lo = $urandom_range(0, pixels - 1);
        if ($urandom_range(0, 19) == 0) begin
          hi = $urandom_range(pixels - 1, lo);
        end else begin
          hi = lo + $urandom_range(0, 20);
        end
        if (hi >= pixels) hi = pixels - 1;
        if ($urandom_range(0, 1) == 0) begin
          r.x_first = ssf_pkg::COL_W'(lo);
          r.x_last  = ssf_pkg::COL_W'(hi);
        end else begin
          r.x_first = ssf_pkg::COL_W'(hi);
          r.x_last  = ssf_pkg::COL_W'(lo);
        end
      end
    end else if (pick < 85) begin
      r.action = ssf_pkg::ACT_READ;
      if (w != 0 && $urandom_range(0, 9) != 0)
        r.byte_addr = ssf_pkg::ADDR_W'($urandom_range(0, w - 1));
    end else if (pick < 93) begin
      r.action = ssf_pkg::ACT_BLANK;
    end else begin
      r.action = ssf_pkg::ACT_NONE;
    end
    return r;
  endfunction

  // Offer one request until taken, record its expected result, then maybe idle.
  task automatic offer_request(input line_req_t r, input row_check_t check,
                               input line_result_t want);
    line_result_t predicted;
    line_result_t expected;
    int unsigned  gap;
    in_ch.valid      <= 1'b1;
    in_ch.action     <= r.action;
    in_ch.x_first    <= r.x_first;
    in_ch.x_last     <= r.x_last;
    in_ch.raster_op  <= r.raster_op;
    in_ch.byte_addr  <= r.byte_addr;
    in_ch.blank_dark <= r.blank_dark;
    do @(posedge clk); while (!in_ch.ready);
    // predictor always runs so the line image tracks; listed rows override the result
    predicted = raster_line_update(r);
    expected  = (check == CHECK_LISTED) ? want : predicted;
    queued_line_results.insert(queued_line_results.size(), expected);
    gap = idle_gap(src_pace);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic finish_outstanding();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (queued_line_results.size() != 0);
  endtask

  // The register is only touched with the block idle.
  task automatic write_active_bytes(input logic [ssf_pkg::CNT_W-1:0] value);
    finish_outstanding();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_bytes_cfg = value;
  endtask

  initial begin : stimulus
    line_req_t   req;
    int unsigned eff;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ssf_pkg::ACT_SPAN;
    in_ch.x_first    = '0;
    in_ch.x_last     = '0;
    in_ch.raster_op  = ssf_pkg::ROP_SET;
    in_ch.byte_addr  = '0;
    in_ch.blank_dark = 1'b0;
    foreach (line_img[i]) line_img[i] = ssf_pkg::BYTE_ZEROS;
    active_bytes_cfg = ssf_pkg::LINE_BYTES_C;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the block's clearing pass after reset holds off the first request
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WIDTH) begin
        write_active_bytes(dir_table[i].width);
      end else begin
        req.action     = dir_table[i].action;
        req.x_first    = dir_table[i].x_first;
        req.x_last     = dir_table[i].x_last;
        req.raster_op  = dir_table[i].raster_op;
        req.byte_addr  = dir_table[i].byte_addr;
        req.blank_dark = dir_table[i].blank_dark;
        offer_request(req, dir_table[i].check, dir_table[i].want);
      end
    end

    // random phases, one register setting each
    foreach (phase_widths[p]) begin
      write_active_bytes(ssf_pkg::CNT_W'(phase_widths[p]));
      eff = (phase_widths[p] > ssf_pkg::LINE_BYTES) ? ssf_pkg::LINE_BYTES : phase_widths[p];
      // first phase runs with no idling on either side
      src_pace  = (p == 0) ? PACE_STEADY : pace_t'($urandom_range(0, 2));
      sink_pace = (p == 0) ? PACE_STEADY : pace_t'($urandom_range(0, 2));
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        // long sink hold-off while requests keep coming, so the input backs up
        if (p == 3 && i == 20) hold_off_req = 1'b1;
        // sender pauses mid-phase until the block has drained
        if (p == 5 && i == 40) finish_outstanding();
        offer_request(random_line_request(eff), CHECK_PREDICTED, QUIET);
      end
    end

    finish_outstanding();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && queued_line_results.size() == 0) begin
      $display("scanline_span_fill_core regression: pass");
    end else begin
      $display("scanline_span_fill_core regression: fail");
    end
    $finish;
  end

  // Result sink: random stalls, plus one long hold-off on request from the stimulus.
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = idle_gap(sink_pace);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    line_result_t want;
    line_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_byte     = out_ch.read_byte;
      got.set_bit_count = out_ch.set_bit_count;
      got.out_of_range  = out_ch.out_of_range;
      if (queued_line_results.size() == 0) begin
        $display("%0t: unexpected result, byte %02h count %0d flag %0b", $time,
                 got.read_byte, got.set_bit_count, got.out_of_range);
        mismatches++;
      end else begin
        want = queued_line_results.pop_front();
        if (got.read_byte !== want.read_byte) begin
          $display("%0t: read_byte expected %02h got %02h", $time,
                   want.read_byte, got.read_byte);
          mismatches++;
        end
        if (got.set_bit_count !== want.set_bit_count) begin
          $display("%0t: set_bit_count expected %0d got %0d", $time,
                   want.set_bit_count, got.set_bit_count);
          mismatches++;
        end
        if (got.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0b got %0b", $time,
                   want.out_of_range, got.out_of_range);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: no request and no result moving for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: watchdog, no traffic for %0d cycles", $time, QUIET_LIMIT);
      $display("scanline_span_fill_core regression: fail");
      $finish;
    end
  end

endmodule
